// ===== rtl/i2cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared command codes, field widths and reset values of the configuration
// registers.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Command codes carried in the action field
    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_WAIT  = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_DELAY_TICKS = 1'b0;
    localparam logic CFG_POLL_LIMIT  = 1'b1;

    // Configuration reset values
    localparam logic [15:0] DELAY_TICKS_RST = 16'd150;
    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd100;

    // Field widths
    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int DELAY_W  = 16;
    localparam int POLL_W   = 8;

    // Delay units per bus step
    localparam logic [2:0] UNITS_1 = 3'd1;
    localparam logic [2:0] UNITS_2 = 3'd2;
    localparam logic [2:0] UNITS_3 = 3'd3;
    localparam logic [2:0] UNITS_5 = 3'd5;

    // Bits per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/i2c_bit_level_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master
// Each input transfer's result is registered. Throughput: one tick item per
// cycle unless a stalled result blocks the input; the next-state logic works
// from the sequencer state registers straight into the result register.
// Reset: synchronous, active low; sequencer idle, SCL and SDA released,
// delay_ticks 150, ack_poll_limit 100, no result pending.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [i2cbm_pkg::DELAY_W-1:0]      cfg_wr_data,
    // tick input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd_valid,
    input  logic [i2cbm_pkg::ACTION_W-1:0]     s_action,
    input  logic [i2cbm_pkg::BYTE_W-1:0]       s_write_data,
    input  logic                               s_send_ack,
    input  logic                               s_sda_in,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_scl_level,
    output logic                               m_sda_level,
    output logic                               m_ready_res,
    output logic                               m_cmd_done,
    output logic [i2cbm_pkg::BYTE_W-1:0]       m_read_data,
    output logic                               m_ack_failed
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_P3, PH_A1, PH_A2, PH_APOLL,
        PH_WSET, PH_WHIGH, PH_WLOW, PH_WTAIL, PH_RLOW, PH_RHIGH, PH_KLOW, PH_KHIGH
    } phase_t;

    // configuration
    logic [i2cbm_pkg::DELAY_W-1:0] delay_ticks_reg;
    logic [i2cbm_pkg::POLL_W-1:0]  poll_limit_reg;

    // sequencer state
    phase_t                        phase_reg, phase_next;
    logic [2:0]                    cur_cmd_reg, cur_cmd_next;
    logic                          ack_choice_reg, ack_choice_next;
    logic [3:0]                    bit_cnt_reg, bit_cnt_next;
    logic [7:0]                    shift_reg, shift_next;
    logic [15:0]                   tick_cnt_reg, tick_cnt_next;
    logic [2:0]                    unit_cnt_reg, unit_cnt_next;
    logic [7:0]                    poll_cnt_reg, poll_cnt_next;
    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic [7:0]                    read_reg, read_next;
    logic                          fail_reg, fail_next;
    logic                          done_next;
    logic                          idle;

    // result register
    logic                          out_valid_reg;

    // helpers
    logic [15:0]                   delay_eff;
    logic [16:0]                   tick_inc;
    logic [2:0]                    unit_dec;
    logic                          do_adv;
    logic                          do_ack;
    logic                          take;

    assign idle      = (phase_reg == PH_IDLE);
    assign delay_eff = (delay_ticks_reg == '0) ? 16'd1 : delay_ticks_reg;
    assign tick_inc  = {1'b0, tick_cnt_reg} + 17'd1;
    assign unit_dec  = (unit_cnt_reg != 3'd0) ? unit_cnt_reg - 3'd1 : 3'd0;

    // accept a tick whenever the result register is free or being drained
    assign s_ready = aresetn && (!out_valid_reg || m_ready);
    assign take    = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    // next sequencer state for one tick
    always_comb begin
        phase_next      = phase_reg;
        cur_cmd_next    = cur_cmd_reg;
        ack_choice_next = ack_choice_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        tick_cnt_next   = tick_cnt_reg;
        unit_cnt_next   = unit_cnt_reg;
        poll_cnt_next   = poll_cnt_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        read_next       = read_reg;
        fail_next       = fail_reg;
        done_next       = 1'b0;
        do_adv          = 1'b0;
        do_ack          = 1'b0;

        if (idle) begin
            // launch a new command
            if (s_cmd_valid && (s_action <= i2cbm_pkg::ACT_READ)) begin
                cur_cmd_next  = s_action;
                bit_cnt_next  = 4'd0;
                poll_cnt_next = 8'd0;
                tick_cnt_next = 16'd0;
                case (s_action)
                    i2cbm_pkg::ACT_START: begin
                        scl_next      = 1'b1;
                        sda_next      = 1'b1;
                        phase_next    = PH_S1;
                        unit_cnt_next = i2cbm_pkg::UNITS_5;
                    end
                    i2cbm_pkg::ACT_STOP: begin
                        scl_next      = 1'b0;
                        sda_next      = 1'b0;
                        phase_next    = PH_P1;
                        unit_cnt_next = i2cbm_pkg::UNITS_3;
                    end
                    i2cbm_pkg::ACT_WRITE: begin
                        shift_next    = s_write_data;
                        scl_next      = 1'b0;
                        sda_next      = s_write_data[7];
                        phase_next    = PH_WSET;
                        unit_cnt_next = i2cbm_pkg::UNITS_2;
                    end
                    i2cbm_pkg::ACT_WAIT: begin
                        sda_next      = 1'b1;
                        phase_next    = PH_A1;
                        unit_cnt_next = i2cbm_pkg::UNITS_1;
                    end
                    default: begin
                        ack_choice_next = s_send_ack;
                        shift_next      = 8'd0;
                        scl_next        = 1'b0;
                        sda_next        = 1'b1;
                        phase_next      = PH_RLOW;
                        unit_cnt_next   = i2cbm_pkg::UNITS_3;
                    end
                endcase
            end
        end else if (phase_reg == PH_APOLL) begin
            do_ack = 1'b1;
        end else begin
            // sample SDA one tick after SCL rises on a read bit
            if (phase_reg == PH_RHIGH && tick_cnt_reg == 16'd0 && unit_cnt_reg == 3'd1) begin
                shift_next = {shift_reg[6:0], s_sda_in};
            end
            // count ticks inside a delay unit
            if (tick_inc >= {1'b0, delay_eff}) begin
                tick_cnt_next = 16'd0;
                unit_cnt_next = unit_dec;
                do_adv        = (unit_dec == 3'd0);
            end else begin
                tick_cnt_next = tick_inc[15:0];
            end
        end

        // step to the next bus phase
        if (do_adv) begin
            case (phase_reg)
                PH_S1: begin
                    sda_next = 1'b0; phase_next = PH_S2; unit_cnt_next = i2cbm_pkg::UNITS_3;
                end
                PH_S2: begin
                    scl_next = 1'b0; phase_next = PH_IDLE; done_next = 1'b1;
                end
                PH_P1: begin
                    scl_next = 1'b1; phase_next = PH_P2; unit_cnt_next = i2cbm_pkg::UNITS_3;
                end
                PH_P2: begin
                    sda_next = 1'b1; phase_next = PH_P3; unit_cnt_next = i2cbm_pkg::UNITS_1;
                end
                PH_P3: begin
                    if (cur_cmd_reg == i2cbm_pkg::ACT_WAIT) begin
                        fail_next = 1'b1;
                    end
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_A1: begin
                    scl_next = 1'b1; phase_next = PH_A2; unit_cnt_next = i2cbm_pkg::UNITS_1;
                end
                PH_A2: begin
                    do_ack = 1'b1;
                end
                PH_WSET: begin
                    scl_next = 1'b1; phase_next = PH_WHIGH; unit_cnt_next = i2cbm_pkg::UNITS_2;
                end
                PH_WHIGH: begin
                    scl_next = 1'b0; phase_next = PH_WLOW; unit_cnt_next = i2cbm_pkg::UNITS_1;
                end
                PH_WLOW: begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    if (bit_cnt_next < i2cbm_pkg::BITS_PER_BYTE) begin
                        shift_next    = {shift_reg[6:0], 1'b0};
                        sda_next      = shift_reg[6];
                        phase_next    = PH_WSET;
                        unit_cnt_next = i2cbm_pkg::UNITS_2;
                    end else begin
                        phase_next    = PH_WTAIL;
                        unit_cnt_next = i2cbm_pkg::UNITS_1;
                    end
                end
                PH_WTAIL: begin
                    phase_next = PH_IDLE; done_next = 1'b1;
                end
                PH_RLOW: begin
                    scl_next = 1'b1; phase_next = PH_RHIGH; unit_cnt_next = i2cbm_pkg::UNITS_1;
                end
                PH_RHIGH: begin
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    scl_next     = 1'b0;
                    if (bit_cnt_next < i2cbm_pkg::BITS_PER_BYTE) begin
                        phase_next    = PH_RLOW;
                        unit_cnt_next = i2cbm_pkg::UNITS_3;
                    end else begin
                        sda_next      = !ack_choice_reg;
                        phase_next    = PH_KLOW;
                        unit_cnt_next = i2cbm_pkg::UNITS_3;
                    end
                end
                PH_KLOW: begin
                    scl_next = 1'b1; phase_next = PH_KHIGH; unit_cnt_next = i2cbm_pkg::UNITS_3;
                end
                PH_KHIGH: begin
                    scl_next   = 1'b0;
                    read_next  = shift_reg;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // decide on the acknowledge sample
        if (do_ack) begin
            if (!s_sda_in) begin
                scl_next   = 1'b0;
                fail_next  = 1'b0;
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end else if (poll_cnt_reg >= poll_limit_reg) begin
                scl_next      = 1'b0;
                sda_next      = 1'b0;
                phase_next    = PH_P1;
                unit_cnt_next = i2cbm_pkg::UNITS_3;
                tick_cnt_next = 16'd0;
            end else begin
                poll_cnt_next = poll_cnt_reg + 8'd1;
                phase_next    = PH_APOLL;
            end
        end
    end

    // hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= i2cbm_pkg::DELAY_TICKS_RST;
            poll_limit_reg  <= i2cbm_pkg::POLL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                i2cbm_pkg::CFG_DELAY_TICKS: delay_ticks_reg <= cfg_wr_data;
                i2cbm_pkg::CFG_POLL_LIMIT:  poll_limit_reg  <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // advance state and register the result on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            cur_cmd_reg    <= 3'd0;
            ack_choice_reg <= 1'b0;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            tick_cnt_reg   <= 16'd0;
            unit_cnt_reg   <= 3'd0;
            poll_cnt_reg   <= 8'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            read_reg       <= 8'd0;
            fail_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (take) begin
                phase_reg      <= phase_next;
                cur_cmd_reg    <= cur_cmd_next;
                ack_choice_reg <= ack_choice_next;
                bit_cnt_reg    <= bit_cnt_next;
                shift_reg      <= shift_next;
                tick_cnt_reg   <= tick_cnt_next;
                unit_cnt_reg   <= unit_cnt_next;
                poll_cnt_reg   <= poll_cnt_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                read_reg       <= read_next;
                fail_reg       <= fail_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take) begin
            m_scl_level  <= scl_next;
            m_sda_level  <= sda_next;
            m_ready_res  <= idle;
            m_cmd_done   <= done_next;
            m_read_data  <= read_next;
            m_ack_failed <= fail_next;
        end
    end

endmodule

// ===== rtl/i2cbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master port checker
// Watches the top-level ports for result handshake and sequencing rules.
// ----------------------------------------------------------------------------
module i2cbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl_level,
    input logic       m_sda_level,
    input logic       m_ready_res,
    input logic       m_cmd_done,
    input logic [7:0] m_read_data,
    input logic       m_ack_failed
);

    logic out_xfer;
    logic last_done_reg;

    assign out_xfer = m_valid && m_ready;

    // remember whether the last delivered result finished a command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_done_reg <= 1'b0;
        end else if (out_xfer) begin
            last_done_reg <= m_cmd_done;
        end
    end

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl_level) && $stable(m_sda_level)
            && $stable(m_ready_res) && $stable(m_cmd_done) && $stable(m_read_data)
            && $stable(m_ack_failed))
        else $error("stalled result changed");

    // drop result valid after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // a stalled result blocks the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // a finished command leaves the sequencer idle for the next tick
    a_idle_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && last_done_reg |-> m_ready_res && !m_cmd_done)
        else $error("not idle after command finished");

endmodule

bind i2c_bit_level_master i2cbm_checker u_i2cbm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_scl_level  (m_scl_level),
    .m_sda_level  (m_sda_level),
    .m_ready_res  (m_ready_res),
    .m_cmd_done   (m_cmd_done),
    .m_read_data  (m_read_data),
    .m_ack_failed (m_ack_failed)
);
